// File: hdl/a2cb_pkg.sv
// ----------------------------------------------------------------------------
// a2cb_pkg - shared types and constants
// Field widths, fixed-point constants and the stage tag of the
// amplitude-to-centibels pipeline.
// ----------------------------------------------------------------------------
package a2cb_pkg;

  localparam int FRACTION_BITS_DEF = 24;

  localparam int AMP_W   = 18;
  localparam int MAG_W   = AMP_W - 1;
  localparam int LEVEL_W = 15;
  localparam int MANT_W  = 63;           // UQ1.62
  localparam int EXP_W   = 5;
  localparam int SCALE_W = 62;           // UQ10.52
  localparam int SPLIT_W = 31;           // scale constant halves
  localparam int LOG_INT = 16;           // log2 of unity gain

  localparam logic [AMP_W-1:0]   AMP_UNITY   = 18'd65536;
  localparam logic [LEVEL_W-1:0] LEVEL_FLOOR = 15'd10000;
  // 2000*log10(2), rounded to nearest
  localparam logic [SCALE_W-1:0] SCALE_Q52   = 62'd2711437152599295475;

  typedef struct packed {
    logic             vld;
    logic             ok;
    logic [EXP_W-1:0] expo;
  } tag_t;

endpackage

// File: hdl/a2cb_norm.sv
// ----------------------------------------------------------------------------
// a2cb_norm - range check and normalization
// Flags factors outside 1..65536, finds the leading one and aligns the
// mantissa to UQ1.62.
// ----------------------------------------------------------------------------
module a2cb_norm (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         vld_in,
  input  logic [a2cb_pkg::AMP_W-1:0]   amp,
  output a2cb_pkg::tag_t               tag,
  output logic [a2cb_pkg::MANT_W-1:0]  mant
);
  import a2cb_pkg::*;

  logic             ok;
  logic [EXP_W-1:0] expo_c;
  logic [MANT_W-1:0] mant_c;

  always_comb begin
    ok     = !amp[AMP_W-1] && (amp != '0) && (amp <= AMP_UNITY);
    expo_c = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (amp[i]) begin
        expo_c = EXP_W'(i);
      end
    end
    mant_c = MANT_W'(amp[MAG_W-1:0]) << (6'(MANT_W - 1) - {1'b0, expo_c});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag <= '0;
    end else if (en) begin
      tag <= '{vld: vld_in, ok: ok, expo: expo_c};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mant <= mant_c;
    end
  end

endmodule

// File: hdl/a2cb_cell.sv
// ----------------------------------------------------------------------------
// a2cb_cell - one fraction bit of log2
// Squares the mantissa (partial products, then sum), takes the integer
// bit as the next fraction bit and renormalizes. Two stages.
// ----------------------------------------------------------------------------
module a2cb_cell #(
  parameter int FB = a2cb_pkg::FRACTION_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  a2cb_pkg::tag_t               tag_in,
  input  logic [a2cb_pkg::MANT_W-1:0]  mant_in,
  input  logic [FB-1:0]                frac_in,
  output a2cb_pkg::tag_t               tag_out,
  output logic [a2cb_pkg::MANT_W-1:0]  mant_out,
  output logic [FB-1:0]                frac_out
);
  import a2cb_pkg::*;

  localparam int LO_W = 32;
  localparam int HI_W = MANT_W - LO_W;
  localparam int SQ_W = 2 * MANT_W;

  logic [LO_W-1:0]        a0;
  logic [HI_W-1:0]        a1;
  logic [2*LO_W-1:0]      p00_c, p00;
  logic [LO_W+HI_W-1:0]   p01_c, p01;
  logic [2*HI_W-1:0]      p11_c, p11;
  tag_t                   tag_a;
  logic [FB-1:0]          frac_a;
  logic [SQ_W-1:0]        sq;
  logic                   bit_c;
  logic [MANT_W-1:0]      mant_next;

  assign a0    = mant_in[LO_W-1:0];
  assign a1    = mant_in[MANT_W-1:LO_W];
  assign p00_c = a0 * a0;
  assign p01_c = a0 * a1;
  assign p11_c = a1 * a1;

  // squaring stage
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_a <= '0;
    end else if (en) begin
      tag_a <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p00    <= p00_c;
      p01    <= p01_c;
      p11    <= p11_c;
      frac_a <= frac_in;
    end
  end

  // sum and renormalize
  always_comb begin
    sq = {p11, {(2*LO_W){1'b0}}} + (SQ_W'(p01) << (LO_W + 1)) + SQ_W'(p00);
    bit_c = sq[SQ_W-1];
    mant_next = bit_c ? sq[SQ_W-1:SQ_W-MANT_W] : sq[SQ_W-2:SQ_W-MANT_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else if (en) begin
      tag_out <= tag_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mant_out <= mant_next;
      frac_out <= {frac_a[FB-2:0], bit_c};
    end
  end

endmodule

// File: hdl/a2cb_scale.sv
// ----------------------------------------------------------------------------
// a2cb_scale - log2 to centibels
// Forms 16 - log2, multiplies by 2000*log10(2) in partial products, then
// rounds, clamps and negates. Five stages.
// ----------------------------------------------------------------------------
module a2cb_scale #(
  parameter int FB = a2cb_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  a2cb_pkg::tag_t                tag_in,
  input  logic [FB-1:0]                 frac_in,
  output logic                          vld_out,
  output logic [a2cb_pkg::LEVEL_W-1:0]  level
);
  import a2cb_pkg::*;

  localparam int LW = FB + EXP_W;
  localparam int LL = (LW + 1) / 2;
  localparam int LH = LW - LL;
  localparam int PW = LW + SCALE_W;

  localparam logic [SPLIT_W-1:0] S_LO = SCALE_Q52[SPLIT_W-1:0];
  localparam logic [SPLIT_W-1:0] S_HI = SCALE_Q52[SCALE_W-1:SPLIT_W];

  logic [4:0]              vld;
  logic [3:0]              ok;
  logic [LW-1:0]           lmag;
  logic [LL+SPLIT_W-1:0]   pp_ll, pp_lh;
  logic [LH+SPLIT_W-1:0]   pp_hl, pp_hh;
  logic [LL+2*SPLIT_W-1:0] sum_l;
  logic [LH+2*SPLIT_W-1:0] sum_h;
  logic [PW-1:0]           prod;
  logic [PW:0]             diff;
  logic [LEVEL_W-1:0]      mag_raw, mag;
  logic [LEVEL_W-1:0]      level_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], tag_in.vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok    <= {ok[2:0], tag_in.ok};
      lmag  <= {EXP_W'(LOG_INT), {FB{1'b0}}} - {tag_in.expo, frac_in};
      pp_ll <= lmag[LL-1:0] * S_LO;
      pp_lh <= lmag[LL-1:0] * S_HI;
      pp_hl <= lmag[LW-1:LL] * S_LO;
      pp_hh <= lmag[LW-1:LL] * S_HI;
      sum_l <= (LL+2*SPLIT_W)'(pp_ll) + ((LL+2*SPLIT_W)'(pp_lh) << SPLIT_W);
      sum_h <= (LH+2*SPLIT_W)'(pp_hl) + ((LH+2*SPLIT_W)'(pp_hh) << SPLIT_W);
      prod  <= PW'(sum_l) + (PW'(sum_h) << LL);
      level <= level_next;
    end
  end

  // subtract one half, truncate, clamp, negate
  always_comb begin
    diff    = {1'b0, prod} - ((PW+1)'(1) << (FB + 51));
    mag_raw = diff[PW-1:FB+52];
    if (diff[PW]) begin
      mag = '0;
    end else if (mag_raw > LEVEL_FLOOR) begin
      mag = LEVEL_FLOOR;
    end else begin
      mag = mag_raw;
    end
    level_next = ok[3] ? (LEVEL_W'(0) - mag) : '0;
  end

  assign vld_out = vld[4];

endmodule

// File: hdl/amplitude_to_centibels_unit.sv
// ----------------------------------------------------------------------------
// amplitude_to_centibels_unit - linear gain to hundredths of a dB
// Pipeline: normalizer, two stages per log2 cell, five scaling stages,
// output register.
// Throughput one word per cycle; the pipeline halts only while the output
// register holds a word not taken by m_tready and the last stage holds a word.
// Reset clears the stage tags and valid bits only; no clearing pass.
// ----------------------------------------------------------------------------
module amplitude_to_centibels_unit #(
  parameter int FRACTION_BITS = a2cb_pkg::FRACTION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,    // [17:0] amplitude_factor
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata     // [14:0] level_centibels
);
  import a2cb_pkg::*;

  tag_t               tag_ch  [0:FRACTION_BITS];
  logic [MANT_W-1:0]  mant_ch [0:FRACTION_BITS];
  logic [FRACTION_BITS-1:0] frac_ch [0:FRACTION_BITS];
  logic               adv;
  logic               last_vld;
  logic [LEVEL_W-1:0] last_level;
  logic [LEVEL_W-1:0] out_level;

  assign adv      = !(m_tvalid && !m_tready && last_vld);
  assign s_tready = adv;

  a2cb_norm u_norm (
    .clk    (clk),
    .rst    (rst),
    .en     (adv),
    .vld_in (s_tvalid),
    .amp    (s_tdata[AMP_W-1:0]),
    .tag    (tag_ch[0]),
    .mant   (mant_ch[0])
  );

  assign frac_ch[0] = '0;

  for (genvar k = 0; k < FRACTION_BITS; k++) begin : g_cell
    a2cb_cell #(.FB(FRACTION_BITS)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .tag_in   (tag_ch[k]),
      .mant_in  (mant_ch[k]),
      .frac_in  (frac_ch[k]),
      .tag_out  (tag_ch[k+1]),
      .mant_out (mant_ch[k+1]),
      .frac_out (frac_ch[k+1])
    );
  end

  a2cb_scale #(.FB(FRACTION_BITS)) u_scale (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .tag_in  (tag_ch[FRACTION_BITS]),
    .frac_in (frac_ch[FRACTION_BITS]),
    .vld_out (last_vld),
    .level   (last_level)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv && last_vld) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && last_vld) begin
      out_level <= last_level;
    end
  end

  assign m_tdata = {1'b0, out_level};

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(out_level) <= 0 && $signed(out_level) >= -15'sd10000))
    else $error("level out of range");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready && last_vld) |=> last_vld)
    else $error("last stage word lost during stall");

  a_norm_lead: assert property (@(posedge clk) disable iff (rst)
    (tag_ch[0].vld && tag_ch[0].ok) |-> mant_ch[0][MANT_W-1])
    else $error("mantissa not normalized");

endmodule
